// ===== rtl/core/streaming_kth_largest_core_defines.svh =====
// Assertion macros for the streaming kth-largest core checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef STREAMING_KTH_LARGEST_CORE_DEFINES_SVH
`define STREAMING_KTH_LARGEST_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KTHL_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kthl checker: property failed");

// Next-cycle implication, disabled while reset is asserted.
`define KTHL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kthl checker: property failed");

`endif

// ===== rtl/core/kthl_pkg.sv =====
// Shared types and constants for the streaming kth-largest core.
// No dependencies; every other file of the block but the macro header imports it.
package kthl_pkg;

  localparam int VALUE_W    = 32;
  localparam int RANK_W     = 7;
  localparam int GRP_W      = 3;
  localparam int GRP_SIZE   = 8;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  // Register map.
  localparam logic [CFG_ADDR_W-1:0] ADDR_RANK_K = 2'd0;
  localparam logic [RANK_W-1:0]     RANK_RESET  = 7'd1;

  // Result value reported when no kth largest value exists.
  localparam logic signed [VALUE_W-1:0] INVALID_VALUE = -32'sd1;

  // Result selector states.
  typedef enum logic [1:0] {
    SEL_IDLE,
    SEL_GROUP,
    SEL_FINAL
  } sel_state_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                     en;
    logic [RANK_W-1:0]        len;
    logic signed [VALUE_W-1:0] value;
  } kthl_bcast_t;

  // Link between neighboring cells.
  typedef struct packed {
    logic                     keep;
    logic signed [VALUE_W-1:0] value;
  } kthl_link_t;

endpackage

// ===== rtl/core/kthl_in_if.sv =====
// Input channel interface: one set element per transfer.
// Depends on kthl_pkg for the value width.
interface kthl_in_if import kthl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// ===== rtl/core/kthl_out_if.sv =====
// Result channel interface: one kth-largest result per transfer.
// Depends on kthl_pkg for the value width.
interface kthl_out_if import kthl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] kth_value;
  logic                      valid_res;

  modport source (output valid, output kth_value, output valid_res, input ready);
  modport sink   (input valid, input kth_value, input valid_res, output ready);
endinterface

// ===== rtl/core/kthl_cell.sv =====
// One cell of the sorted insertion chain: holds one kept value.
// Depends on kthl_pkg for the broadcast and link structs.
module kthl_cell import kthl_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic        clk,
  input  kthl_bcast_t bcast,
  input  kthl_link_t  prev,
  output kthl_link_t  next
);

  logic signed [VALUE_W-1:0] value_r;
  logic signed [VALUE_W-1:0] value_nxt;
  logic                      occupied;

  // A cell keeps its value when it is occupied and not smaller than the new value.
  assign occupied   = int'(bcast.len) > INDEX;
  assign next.keep  = occupied && ($signed(value_r) >= $signed(bcast.value));
  assign next.value = value_r;

  // Hold, take the new value at the insertion point, or shift down from the neighbor.
  always_comb begin
    priority if (!bcast.en) begin
      value_nxt = value_r;
    end else if (next.keep) begin
      value_nxt = value_r;
    end else if (prev.keep) begin
      value_nxt = bcast.value;
    end else begin
      value_nxt = prev.value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

// ===== rtl/core/streaming_kth_largest_core.sv =====
// Streaming kth-largest selector.
// Elements of a set arrive on in_if (value, last) with valid/ready; a transfer
// happens on a clock edge where both are high. One element is taken per cycle
// within a set. The block keeps the rank_k largest values in a descending chain
// of compare cells, one value per cell, updated in the cycle of each transfer.
// After the transfer that carries last, in_if.ready drops while a two-stage
// registered selector picks cell rank_k-1 (8:1 per group, then across groups);
// it stays low until the result is loaded into the output register.
// kth_value is -1 with valid_res low when rank_k is zero, above MAX_RANK, or
// the set held fewer than rank_k values.
// The result sits in an output register, so new elements are still taken while
// out_if is stalled; the selector waits for it to drain, with in_if.ready low.
// rank_k is written through the cfg_ APB port at address 0 (reset value 1).
// Reset (rst_n low, synchronous) empties the chain and clears out_if.valid.
module streaming_kth_largest_core import kthl_pkg::*; #(
  parameter int MAX_RANK = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  kthl_in_if.sink               in_if,
  kthl_out_if.source            out_if,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int GROUPS = (MAX_RANK + GRP_SIZE - 1) / GRP_SIZE;
  localparam int HI_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int SEL_W  = GRP_W + HI_W;

  logic [RANK_W-1:0]         rank_r;
  logic [RANK_W-1:0]         count_r, count_nxt;
  sel_state_t                state_r, state_nxt;
  logic [SEL_W-1:0]          sel_r;
  logic                      ok_r;
  logic signed [VALUE_W-1:0] grp_r [GROUPS];
  logic                      out_v_r, out_v_nxt;
  logic signed [VALUE_W-1:0] out_val_r;
  logic                      out_ok_r;

  logic                      in_xfer, out_xfer, cfg_wr;
  logic                      usable, load_out;
  logic [RANK_W-1:0]         len, upd_count;
  kthl_bcast_t               bcast;
  kthl_link_t                link [MAX_RANK+1];
  logic signed [VALUE_W-1:0] pad [GROUPS][GRP_SIZE];

  // Configuration port: one register, no wait states.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == ADDR_RANK_K) ? CFG_DATA_W'(rank_r) : '0;

  // Handshakes.
  assign in_xfer  = in_if.valid && in_if.ready;
  assign out_xfer = out_if.valid && out_if.ready;
  assign in_if.ready = (state_r == SEL_IDLE);

  // Effective fill and the fill after inserting one more value.
  assign usable    = (rank_r != '0) && (int'(rank_r) <= MAX_RANK);
  assign len       = (count_r < rank_r) ? count_r : rank_r;
  assign upd_count = (len < rank_r) ? len + 7'd1 : rank_r;

  // Broadcast to the chain.
  assign bcast.en    = in_xfer && usable;
  assign bcast.len   = len;
  assign bcast.value = in_if.value;

  // Head of the chain always counts as keeping, so cell 0 can take the new value.
  assign link[0].keep  = 1'b1;
  assign link[0].value = in_if.value;

  for (genvar i = 0; i < MAX_RANK; i++) begin : g_cell
    kthl_cell #(.INDEX(i)) u_cell (
      .clk   (clk),
      .bcast (bcast),
      .prev  (link[i]),
      .next  (link[i+1])
    );
  end

  // Cell values grouped by eight for the first selector stage.
  for (genvar g = 0; g < GROUPS; g++) begin : g_grp
    for (genvar j = 0; j < GRP_SIZE; j++) begin : g_slot
      if (g * GRP_SIZE + j < MAX_RANK) begin : g_used
        assign pad[g][j] = link[g*GRP_SIZE+j+1].value;
      end else begin : g_empty
        assign pad[g][j] = '0;
      end
    end
  end

  // Fill count: cleared by the last transfer of a set.
  always_comb begin
    count_nxt = count_r;
    if (in_xfer) begin
      if (in_if.last) begin
        count_nxt = '0;
      end else if (usable) begin
        count_nxt = upd_count;
      end
    end
  end

  // Selector sequencing.
  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    unique case (state_r)
      SEL_IDLE: begin
        if (in_xfer && in_if.last) state_nxt = SEL_GROUP;
      end
      SEL_GROUP: begin
        state_nxt = SEL_FINAL;
      end
      SEL_FINAL: begin
        if (!out_v_r || out_if.ready) begin
          load_out  = 1'b1;
          state_nxt = SEL_IDLE;
        end
      end
      default: begin
        state_nxt = SEL_IDLE;
      end
    endcase
  end

  // Output register occupancy.
  always_comb begin
    out_v_nxt = out_v_r;
    if (load_out) begin
      out_v_nxt = 1'b1;
    end else if (out_xfer) begin
      out_v_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r  <= RANK_RESET;
      count_r <= '0;
      state_r <= SEL_IDLE;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_wr && (cfg_paddr == ADDR_RANK_K)) rank_r <= cfg_pwdata[RANK_W-1:0];
      count_r <= count_nxt;
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Result capture and the two selector stages.
  always_ff @(posedge clk) begin
    if (in_xfer && in_if.last) begin
      sel_r <= SEL_W'(rank_r - 7'd1);
      ok_r  <= usable && (upd_count >= rank_r);
    end
    if (state_r == SEL_GROUP) begin
      for (int g = 0; g < GROUPS; g++) begin
        grp_r[g] <= pad[g][sel_r[GRP_W-1:0]];
      end
    end
    if (load_out) begin
      out_val_r <= ok_r ? grp_r[sel_r[SEL_W-1:GRP_W]] : INVALID_VALUE;
      out_ok_r  <= ok_r;
    end
  end

  assign out_if.valid     = out_v_r;
  assign out_if.kth_value = out_val_r;
  assign out_if.valid_res = out_ok_r;

endmodule

// ===== rtl/core/kthl_checker.sv =====
// Port-level checker for the streaming kth-largest core, bound to the top level.
// Depends on kthl_pkg, both channel interfaces and the assertion macro header.
`include "streaming_kth_largest_core_defines.svh"

module kthl_checker import kthl_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  kthl_in_if.sink    in_if,
  kthl_out_if.source out_if
);

  // The transfer that closes a set stalls the input while the result is selected.
  `KTHL_ASSERT_NEXT(a_last_stalls, in_if.valid && in_if.ready && in_if.last, !in_if.ready)

  // An invalid result always carries the invalid code.
  `KTHL_ASSERT_IMPLY(a_invalid_code, out_if.valid && !out_if.valid_res, out_if.kth_value == INVALID_VALUE)

  // A new result is only loaded while the selector holds the input off.
  `KTHL_ASSERT_IMPLY(a_load_in_select, $rose(out_if.valid), $past(!in_if.ready))

  // A stalled result stays offered and unchanged.
  `KTHL_ASSERT_NEXT(a_out_hold, out_if.valid && !out_if.ready, out_if.valid)
  `KTHL_ASSERT_NEXT(a_out_stable, out_if.valid && !out_if.ready, $stable(out_if.kth_value) && $stable(out_if.valid_res))

endmodule

bind streaming_kth_largest_core kthl_checker u_kthl_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_if  (in_if),
  .out_if (out_if)
);
